### src/vector3_arithmetic_unit_core_assert.svh
// Assertion macros for the vector unit core.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef VECTOR3_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define VECTOR3_ARITHMETIC_UNIT_CORE_ASSERT_SVH

// Same-cycle implication
`define VAU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define VAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/vau_pkg.sv
package vau_pkg;

    // Fixed-point format and datapath widths
    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int PROD_W    = 2 * DW;          // one full product
    localparam int ACC_W     = PROD_W + 2;      // sum of three products, with headroom
    localparam int SQ_W      = PROD_W;          // radicand width
    localparam int SQ_STEPS  = SQ_W / 2;        // one root bit per stage
    localparam int ROOT_W    = DW + 1;          // rounded root
    localparam int NUM_W     = DW + FRAC_BITS;  // dividend |a| << FRAC_BITS
    localparam int REM_W     = ROOT_W + 1;      // divider partial remainder
    localparam int LATENCY   = 4 + SQ_STEPS + 1 + NUM_W + 1;

    // Rounding constant: one half LSB of the result
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

    // Operation codes
    localparam logic [3:0] FN_ADD   = 4'd0;
    localparam logic [3:0] FN_SUB   = 4'd1;
    localparam logic [3:0] FN_MUL   = 4'd2;
    localparam logic [3:0] FN_SCALE = 4'd3;
    localparam logic [3:0] FN_DIV   = 4'd4;
    localparam logic [3:0] FN_DOT   = 4'd5;
    localparam logic [3:0] FN_CROSS = 4'd6;
    localparam logic [3:0] FN_MAG   = 4'd7;
    localparam logic [3:0] FN_NORM  = 4'd8;

    typedef struct packed {
        logic [3:0]           func;
        logic signed [DW-1:0] a_x;
        logic signed [DW-1:0] a_y;
        logic signed [DW-1:0] a_z;
        logic signed [DW-1:0] b_x;
        logic signed [DW-1:0] b_y;
        logic signed [DW-1:0] b_z;
        logic signed [DW-1:0] scalar_in;
    } vau_in_t;

    typedef struct packed {
        logic signed [DW-1:0] r_x;
        logic signed [DW-1:0] r_y;
        logic signed [DW-1:0] r_z;
        logic signed [DW-1:0] scalar_out;
        logic                 div_error;
        logic                 saturated;
    } vau_out_t;

    // What travels down the root and divider pipes with each word
    typedef struct packed {
        logic [3:0]           func;
        logic signed [DW-1:0] a_x;
        logic signed [DW-1:0] a_y;
        logic signed [DW-1:0] a_z;
        logic signed [DW-1:0] scalar_in;
        vau_out_t             res;
    } vau_meta_t;

    typedef struct packed {
        logic                 clip;
        logic signed [DW-1:0] val;
    } vau_sat_t;

    // Clip a wide signed value to the 32-bit range
    function automatic vau_sat_t sat_fx(input logic signed [ACC_W-1:0] v);
        vau_sat_t r;
        if (v[ACC_W-1:DW-1] == '0 || v[ACC_W-1:DW-1] == '1) begin
            r.clip = 1'b0;
            r.val  = v[DW-1:0];
        end
        else if (v[ACC_W-1]) begin
            r.clip = 1'b1;
            r.val  = {1'b1, {(DW-1){1'b0}}};
        end
        else begin
            r.clip = 1'b1;
            r.val  = {1'b0, {(DW-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

### src/vector3_arithmetic_unit_core.sv
// Channel   | Signals              | Handshake
// ----------+----------------------+-----------------------------------------
// command   | start, busy, cmd     | word taken at clk edge with start & !busy
// result    | done, result         | word valid for the single cycle done=1
//
// One word enters every cycle; busy stays low. A command loads the input
// register at its accepting edge; the word then passes through 4 front stages
// (input, select/multiply, combine, round/saturate), 32 square-root stages,
// one root-rounding stage, 48 divider stages (one quotient bit each) and the
// output register.
// Reset (rst_n low, async) clears every valid bit; the result side cannot
// stall, so words flow without holding.
`include "vector3_arithmetic_unit_core_assert.svh"

module vector3_arithmetic_unit_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  vau_pkg::vau_in_t  cmd,
    output logic              busy,
    output logic              done,
    output vau_pkg::vau_out_t result
);
    localparam int DW        = vau_pkg::DW;
    localparam int PROD_W    = vau_pkg::PROD_W;
    localparam int ACC_W     = vau_pkg::ACC_W;
    localparam int SQ_W      = vau_pkg::SQ_W;
    localparam int SQ_STEPS  = vau_pkg::SQ_STEPS;
    localparam int ROOT_W    = vau_pkg::ROOT_W;
    localparam int NUM_W     = vau_pkg::NUM_W;
    localparam int FRAC_BITS = vau_pkg::FRAC_BITS;

    // ---------------- stage 0: input register ----------------
    logic             in_v_reg;
    vau_pkg::vau_in_t in_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg <= cmd;
    end

    // ---------------- stage 1: operand select, multiply ----------------
    logic signed [DW-1:0]     av [3];
    logic signed [DW-1:0]     bv [3];
    logic signed [DW-1:0]     ea [3];
    logic signed [DW-1:0]     eb [3];
    logic signed [DW-1:0]     oa [3];
    logic signed [DW-1:0]     ob [3];
    logic signed [PROD_W-1:0] pe_next [3];
    logic signed [PROD_W-1:0] po_next [3];
    logic signed [DW:0]       as_next [3];

    assign av = '{in_reg.a_x, in_reg.a_y, in_reg.a_z};
    assign bv = '{in_reg.b_x, in_reg.b_y, in_reg.b_z};

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ea[c] = av[c];
            eb[c] = bv[c];
            oa[c] = '0;
            ob[c] = '0;
            if (in_reg.func == vau_pkg::FN_SCALE)
                eb[c] = in_reg.scalar_in;
            else if (in_reg.func == vau_pkg::FN_MAG || in_reg.func == vau_pkg::FN_NORM)
                eb[c] = av[c];
        end
        // cross product pairs
        if (in_reg.func == vau_pkg::FN_CROSS)
        begin
            ea[0] = av[1]; eb[0] = bv[2]; oa[0] = av[2]; ob[0] = bv[1];
            ea[1] = av[2]; eb[1] = bv[0]; oa[1] = av[0]; ob[1] = bv[2];
            ea[2] = av[0]; eb[2] = bv[1]; oa[2] = av[1]; ob[2] = bv[0];
        end
        for (int c = 0; c < 3; c++)
        begin
            pe_next[c] = PROD_W'(ea[c]) * PROD_W'(eb[c]);
            po_next[c] = PROD_W'(oa[c]) * PROD_W'(ob[c]);
            if (in_reg.func == vau_pkg::FN_SUB)
                as_next[c] = (DW+1)'(av[c]) - (DW+1)'(bv[c]);
            else
                as_next[c] = (DW+1)'(av[c]) + (DW+1)'(bv[c]);
        end
    end

    logic                     p1_v_reg;
    vau_pkg::vau_in_t         p1_reg;
    logic signed [PROD_W-1:0] pe_reg [3];
    logic signed [PROD_W-1:0] po_reg [3];
    logic signed [DW:0]       as1_reg [3];

    always_ff @(posedge clk)
    begin
        p1_reg <= in_reg;
        for (int c = 0; c < 3; c++)
        begin
            pe_reg[c]  <= pe_next[c];
            po_reg[c]  <= po_next[c];
            as1_reg[c] <= as_next[c];
        end
    end

    // ---------------- stage 2: differences and dot sum ----------------
    logic                    p2_v_reg;
    vau_pkg::vau_in_t        p2_reg;
    logic signed [ACC_W-1:0] dif_reg [3];
    logic signed [ACC_W-1:0] dot_reg;
    logic signed [DW:0]      as2_reg [3];

    always_ff @(posedge clk)
    begin
        p2_reg  <= p1_reg;
        dot_reg <= ACC_W'(pe_reg[0]) + ACC_W'(pe_reg[1]) + ACC_W'(pe_reg[2]);
        for (int c = 0; c < 3; c++)
        begin
            dif_reg[c] <= ACC_W'(pe_reg[c]) - ACC_W'(po_reg[c]);
            as2_reg[c] <= as1_reg[c];
        end
    end

    // ---------------- stage 3: round and saturate simple ops ----------------
    logic signed [ACC_W-1:0] rnd [3];
    logic signed [ACC_W-1:0] dot_rnd;
    vau_pkg::vau_sat_t       sv [3];
    vau_pkg::vau_sat_t       sa [3];
    vau_pkg::vau_sat_t       sd;
    vau_pkg::vau_meta_t      s3_next;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            rnd[c] = (dif_reg[c] + vau_pkg::RND_HALF) >>> FRAC_BITS;
            sv[c]  = vau_pkg::sat_fx(rnd[c]);
            sa[c]  = vau_pkg::sat_fx(ACC_W'(as2_reg[c]));
        end
        dot_rnd = (dot_reg + vau_pkg::RND_HALF) >>> FRAC_BITS;
        sd      = vau_pkg::sat_fx(dot_rnd);

        s3_next.func      = p2_reg.func;
        s3_next.a_x       = p2_reg.a_x;
        s3_next.a_y       = p2_reg.a_y;
        s3_next.a_z       = p2_reg.a_z;
        s3_next.scalar_in = p2_reg.scalar_in;
        s3_next.res       = '0;
        unique case (p2_reg.func)
            vau_pkg::FN_ADD, vau_pkg::FN_SUB:
            begin
                s3_next.res.r_x       = sa[0].val;
                s3_next.res.r_y       = sa[1].val;
                s3_next.res.r_z       = sa[2].val;
                s3_next.res.saturated = sa[0].clip | sa[1].clip | sa[2].clip;
            end
            vau_pkg::FN_MUL, vau_pkg::FN_SCALE, vau_pkg::FN_CROSS:
            begin
                s3_next.res.r_x       = sv[0].val;
                s3_next.res.r_y       = sv[1].val;
                s3_next.res.r_z       = sv[2].val;
                s3_next.res.saturated = sv[0].clip | sv[1].clip | sv[2].clip;
            end
            vau_pkg::FN_DOT:
            begin
                s3_next.res.scalar_out = sd.val;
                s3_next.res.saturated  = sd.clip;
            end
            default:
            begin
            end
        endcase
    end

    logic               s3_v_reg;
    vau_pkg::vau_meta_t s3_reg;
    logic [SQ_W-1:0]    s3_sq_reg;   // sum of squares for magnitude/normalize

    always_ff @(posedge clk)
    begin
        s3_reg    <= s3_next;
        s3_sq_reg <= dot_reg[SQ_W-1:0];
    end

    // ---------------- square root pipe: one root bit per stage ----------------
    logic [SQ_W-1:0]    sq_rem_reg   [SQ_STEPS];
    logic [SQ_W-1:0]    sq_rem_next  [SQ_STEPS];
    logic [SQ_W-1:0]    sq_root_reg  [SQ_STEPS];
    logic [SQ_W-1:0]    sq_root_next [SQ_STEPS];
    vau_pkg::vau_meta_t sq_meta_reg  [SQ_STEPS];
    logic [SQ_STEPS-1:0] sq_v_reg;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT_K = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        logic [SQ_W-1:0] rem_in;
        logic [SQ_W-1:0] root_in;
        logic [SQ_W:0]   trial;
        logic            fits;

        if (k == 0) begin : g_first
            assign rem_in  = s3_sq_reg;
            assign root_in = '0;
        end
        else begin : g_rest
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
        end

        assign trial           = {1'b0, root_in} + {1'b0, BIT_K};
        assign fits            = {1'b0, rem_in} >= trial;
        assign sq_rem_next[k]  = fits ? rem_in - trial[SQ_W-1:0] : rem_in;
        assign sq_root_next[k] = fits ? (root_in >> 1) + BIT_K : root_in >> 1;
    end

    always_ff @(posedge clk)
    begin
        sq_meta_reg[0] <= s3_reg;
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            sq_rem_reg[k]  <= sq_rem_next[k];
            sq_root_reg[k] <= sq_root_next[k];
        end
        for (int k = 1; k < SQ_STEPS; k++)
        begin
            sq_meta_reg[k] <= sq_meta_reg[k-1];
        end
    end

    // ---------------- root rounding, divisor and dividend setup ----------------
    logic [SQ_W-1:0]    root_last;
    logic [SQ_W-1:0]    rem_last;
    logic [ROOT_W-1:0]  root_rnd;
    logic [DW-1:0]      s_abs;
    logic [DW-1:0]      a_abs [3];
    logic signed [DW-1:0] am [3];
    vau_pkg::vau_sat_t  mag_sat;
    vau_pkg::vau_meta_t m_next;
    logic [ROOT_W-1:0]  den_next;

    assign root_last = sq_root_reg[SQ_STEPS-1];
    assign rem_last  = sq_rem_reg[SQ_STEPS-1];
    // round to nearest: remainder beyond the root means the upper half
    assign root_rnd  = ROOT_W'(root_last) + ROOT_W'(rem_last > root_last);
    assign mag_sat   = vau_pkg::sat_fx($signed(ACC_W'(root_rnd)));

    always_comb
    begin
        m_next = sq_meta_reg[SQ_STEPS-1];
        am[0]  = m_next.a_x;
        am[1]  = m_next.a_y;
        am[2]  = m_next.a_z;
        for (int c = 0; c < 3; c++)
            a_abs[c] = am[c][DW-1] ? DW'(-am[c]) : DW'(am[c]);
        s_abs    = m_next.scalar_in[DW-1] ? DW'(-m_next.scalar_in) : DW'(m_next.scalar_in);
        den_next = ROOT_W'(s_abs);
        unique case (m_next.func)
            vau_pkg::FN_MAG:
            begin
                m_next.res.scalar_out = mag_sat.val;
                m_next.res.saturated  = mag_sat.clip;
            end
            vau_pkg::FN_DIV:
            begin
                m_next.res.div_error = (m_next.scalar_in == '0);
            end
            vau_pkg::FN_NORM:
            begin
                den_next             = root_rnd;
                m_next.res.div_error = (root_rnd == '0);
            end
            default:
            begin
            end
        endcase
    end

    logic               m_v_reg;
    vau_pkg::vau_meta_t m_meta_reg;
    logic [NUM_W-1:0]   num_reg [3];
    logic [ROOT_W-1:0]  den_reg;

    always_ff @(posedge clk)
    begin
        m_meta_reg <= m_next;
        den_reg    <= den_next;
        for (int c = 0; c < 3; c++)
            num_reg[c] <= {a_abs[c], {FRAC_BITS{1'b0}}};
    end

    // ---------------- divider lanes ----------------
    logic [NUM_W-1:0] quo [3];

    for (genvar c = 0; c < 3; c++) begin : g_lane
        vau_div_lane u_div (
            .clk (clk),
            .num (num_reg[c]),
            .den (den_reg),
            .quo (quo[c])
        );
    end

    vau_pkg::vau_meta_t dv_meta_reg [NUM_W];
    logic [NUM_W-1:0]   dv_v_reg;

    always_ff @(posedge clk)
    begin
        dv_meta_reg[0] <= m_meta_reg;
        for (int j = 1; j < NUM_W; j++)
            dv_meta_reg[j] <= dv_meta_reg[j-1];
    end

    // ---------------- final: sign quotients, saturate ----------------
    vau_pkg::vau_meta_t   f_meta;
    vau_pkg::vau_out_t    fin;
    logic                 f_v;
    logic                 neg [3];
    logic signed [ACC_W-1:0] qv [3];
    vau_pkg::vau_sat_t    sq [3];

    assign f_meta = dv_meta_reg[NUM_W-1];
    assign f_v    = dv_v_reg[NUM_W-1];

    always_comb
    begin
        fin    = f_meta.res;
        neg[0] = f_meta.a_x[DW-1];
        neg[1] = f_meta.a_y[DW-1];
        neg[2] = f_meta.a_z[DW-1];
        for (int c = 0; c < 3; c++)
        begin
            if (f_meta.func == vau_pkg::FN_DIV)
                neg[c] = neg[c] ^ f_meta.scalar_in[DW-1];
            qv[c] = neg[c] ? -$signed(ACC_W'(quo[c])) : $signed(ACC_W'(quo[c]));
            sq[c] = vau_pkg::sat_fx(qv[c]);
        end
        if ((f_meta.func == vau_pkg::FN_DIV || f_meta.func == vau_pkg::FN_NORM)
            && !f_meta.res.div_error)
        begin
            fin.r_x       = sq[0].val;
            fin.r_y       = sq[1].val;
            fin.r_z       = sq[2].val;
            fin.saturated = sq[0].clip | sq[1].clip | sq[2].clip;
        end
    end

    logic              done_reg;
    vau_pkg::vau_out_t result_reg;

    always_ff @(posedge clk)
    begin
        if (f_v)
            result_reg <= fin;
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            sq_v_reg <= '0;
            m_v_reg  <= 1'b0;
            dv_v_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            p1_v_reg <= in_v_reg;
            p2_v_reg <= p1_v_reg;
            s3_v_reg <= p2_v_reg;
            sq_v_reg <= {sq_v_reg[SQ_STEPS-2:0], s3_v_reg};
            m_v_reg  <= sq_v_reg[SQ_STEPS-1];
            dv_v_reg <= {dv_v_reg[NUM_W-2:0], m_v_reg};
            done_reg <= f_v;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ---------------- assertions ----------------
    logic cmd_take;
    logic res_zero;
    logic norm_live;

    assign cmd_take  = start && !busy;
    assign res_zero  = result.r_x == '0 && result.r_y == '0 && result.r_z == '0
                       && result.scalar_out == '0 && !result.saturated;
    assign norm_live = m_v_reg && m_meta_reg.func == vau_pkg::FN_NORM
                       && !m_meta_reg.res.div_error;

    `VAU_ASSERT_NOW(a_latency, done, $past(cmd_take, vau_pkg::LATENCY), "result word without command")
    `VAU_ASSERT_NOW(a_err_zero, done && result.div_error, res_zero, "error word not zero")
    `VAU_ASSERT_NOW(a_norm_den, norm_live, den_reg != '0, "normalize divides by zero root")

endmodule

### src/vau_div_lane.sv
// Fully pipelined restoring divider: one quotient bit per stage.
module vau_div_lane (
    input  logic                       clk,
    input  logic [vau_pkg::NUM_W-1:0]  num,
    input  logic [vau_pkg::ROOT_W-1:0] den,
    output logic [vau_pkg::NUM_W-1:0]  quo
);
    localparam int NUM_W  = vau_pkg::NUM_W;
    localparam int ROOT_W = vau_pkg::ROOT_W;
    localparam int REM_W  = vau_pkg::REM_W;

    logic [REM_W-1:0]  rem_reg  [NUM_W];
    logic [REM_W-1:0]  rem_next [NUM_W];
    logic [NUM_W-1:0]  acc_reg  [NUM_W];   // dividend bits shift out, quotient bits in
    logic [NUM_W-1:0]  acc_next [NUM_W];
    logic [ROOT_W-1:0] den_reg  [NUM_W-1];

    for (genvar j = 0; j < NUM_W; j++) begin : g_step
        logic [REM_W-1:0]  rem_in;
        logic [NUM_W-1:0]  acc_in;
        logic [ROOT_W-1:0] den_in;
        logic [REM_W-1:0]  trial;
        logic              fits;

        if (j == 0) begin : g_first
            assign rem_in = '0;
            assign acc_in = num;
            assign den_in = den;
        end
        else begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign acc_in = acc_reg[j-1];
            assign den_in = den_reg[j-1];
        end

        // shift in the next dividend bit, subtract if the divisor fits
        assign trial       = {rem_in[REM_W-2:0], acc_in[NUM_W-1]};
        assign fits        = trial >= {1'b0, den_in};
        assign rem_next[j] = fits ? trial - {1'b0, den_in} : trial;
        assign acc_next[j] = {acc_in[NUM_W-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        den_reg[0] <= den;
        for (int j = 0; j < NUM_W; j++)
        begin
            rem_reg[j] <= rem_next[j];
            acc_reg[j] <= acc_next[j];
        end
        for (int j = 1; j < NUM_W - 1; j++)
        begin
            den_reg[j] <= den_reg[j-1];
        end
    end

    assign quo = acc_reg[NUM_W-1];

endmodule
